// File: hdl/tt_pkg.sv
// Shared types, constants and command codes for the transposition table.
`timescale 1ns / 1ps

package tt_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int MATE_SCORE_DEF = 32000;
    localparam int MAX_PLY_DEF    = 128;

    localparam int OCC_SLOTS = 1000;
    localparam int KEY_W     = 64;
    localparam int PLY_W     = 7;
    localparam int SCORE_W   = 16;
    localparam int DEPTH_W   = 8;
    localparam int PAYLOAD_W = 16;
    localparam int AGE_W     = 6;
    localparam int OCC_W     = 10;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_OCCUPY = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0]            key;
        logic signed [SCORE_W-1:0]   score;
        logic signed [DEPTH_W-1:0]   depth;
        logic [PAYLOAD_W-1:0]        payload;
        logic [AGE_W-1:0]            age;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic lookup_done;
        logic walk_rd;
        logic walk_clr;
        logic finish;
    } tt_ctrl_t;

    typedef struct packed {
        logic walk_occ_end;
        logic walk_top;
        logic out_free;
    } tt_status_t;

endpackage

// File: hdl/tt_ctrl.sv
// Controller state machine sequencing lookups, occupancy walks and clears.
`timescale 1ns / 1ps

module tt_ctrl
    import tt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] command,
    output logic       in_ready,
    input  tt_status_t status,
    output tt_ctrl_t   ctrl
);

    typedef enum logic [6:0] {
        S_INIT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_LOOKUP   = 7'b0000100,
        S_OCC_WALK = 7'b0001000,
        S_OCC_TAIL = 7'b0010000,
        S_CLEAR    = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ctrl.walk_clr = 1'b1;
                if (status.walk_top)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    case (cmd_t'(command))
                        CMD_READ, CMD_WRITE: state_next = S_LOOKUP;
                        CMD_CLEAR:           state_next = S_CLEAR;
                        CMD_OCCUPY:          state_next = S_OCC_WALK;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (status.out_free)
                begin
                    ctrl.lookup_done = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_OCC_WALK:
            begin
                ctrl.walk_rd = 1'b1;
                if (status.walk_occ_end)
                begin
                    state_next = S_OCC_TAIL;
                end
            end
            S_OCC_TAIL:
            begin
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                ctrl.walk_clr = 1'b1;
                if (status.walk_top)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/tt_datapath.sv
// Datapath: slot memory, request registers, mate adjust, walk counter and result register.
`timescale 1ns / 1ps

module tt_datapath
    import tt_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int MATE_SCORE = MATE_SCORE_DEF,
    parameter int MAX_PLY    = MAX_PLY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [AGE_W-1:0]            cfg_data,
    input  logic [1:0]                  command,
    input  logic [KEY_W-1:0]            key,
    input  logic [PLY_W-1:0]            ply,
    input  logic signed [SCORE_W-1:0]   entry_score,
    input  logic signed [DEPTH_W-1:0]   entry_depth,
    input  logic [PAYLOAD_W-1:0]        entry_payload,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        hit,
    output logic signed [SCORE_W-1:0]   out_score,
    output logic signed [DEPTH_W-1:0]   out_depth,
    output logic [PAYLOAD_W-1:0]        out_payload,
    output logic [AGE_W-1:0]            out_age,
    output logic                        stored,
    output logic [OCC_W-1:0]            occupancy,
    input  tt_ctrl_t                    ctrl,
    output tt_status_t                  status
);

    localparam int SLOTS = 1 << INDEX_BITS;
    localparam logic signed [17:0] LIM    = 18'(MATE_SCORE - MAX_PLY);
    localparam logic signed [17:0] SAT_HI = 18'sd32767;
    localparam logic signed [17:0] SAT_LO = -18'sd32767;

    slot_t slot_mem [SLOTS];
    slot_t rd_data_reg;

    cmd_t                       cmd_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [PLY_W-1:0]           ply_reg;
    logic signed [SCORE_W-1:0]  score_reg;
    logic signed [DEPTH_W-1:0]  depth_reg;
    logic [PAYLOAD_W-1:0]       payload_reg;
    logic [AGE_W-1:0]           age_reg;
    logic [INDEX_BITS-1:0]      walk_reg;
    logic                       cnt_en_reg;
    logic [OCC_W-1:0]           count_reg;
    logic                       out_valid_reg;

    logic [INDEX_BITS-1:0]      mem_addr;
    logic                       mem_we;
    logic                       mem_re;
    slot_t                      mem_wdata;
    logic                       key_match;
    logic                       replace;
    logic signed [SCORE_W-1:0]  rd_score_adj;
    logic signed [SCORE_W-1:0]  wr_score_adj;
    logic                       count_hit;
    logic                       load;

    function automatic logic signed [SCORE_W-1:0] mate_adj(
        input logic signed [SCORE_W-1:0] s,
        input logic [PLY_W-1:0]          p,
        input logic                      into
    );
        logic signed [17:0] sx;
        logic signed [17:0] px;
        logic signed [17:0] r;
        sx = 18'(s);
        px = $signed({11'b0, p});
        if (sx >= LIM)
        begin
            r = into ? sx + px : sx - px;
        end
        else if (sx <= -LIM)
        begin
            r = into ? sx - px : sx + px;
        end
        else
        begin
            r = sx;
        end
        if (r > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (r < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[SCORE_W-1:0];
    endfunction

    assign key_match    = (rd_data_reg.key == key_reg);
    assign replace      = (rd_data_reg.age != age_reg) || (depth_reg >= rd_data_reg.depth);
    assign rd_score_adj = mate_adj(rd_data_reg.score, ply_reg, 1'b0);
    assign wr_score_adj = mate_adj(score_reg, ply_reg, 1'b1);
    assign count_hit    = cnt_en_reg && (rd_data_reg.key != '0) && (rd_data_reg.age == age_reg);

    always_comb
    begin
        mem_addr  = walk_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = '0;
        if (ctrl.accept)
        begin
            mem_addr = key[INDEX_BITS-1:0];
            mem_re   = 1'b1;
        end
        else if (ctrl.lookup_done)
        begin
            mem_addr          = key_reg[INDEX_BITS-1:0];
            mem_we            = (cmd_reg == CMD_WRITE) && replace;
            mem_wdata.key     = key_reg;
            mem_wdata.score   = wr_score_adj;
            mem_wdata.depth   = depth_reg;
            mem_wdata.payload = payload_reg;
            mem_wdata.age     = age_reg;
        end
        else if (ctrl.walk_rd)
        begin
            mem_re = 1'b1;
        end
        else if (ctrl.walk_clr)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg     <= cmd_t'(command);
            key_reg     <= key;
            ply_reg     <= ply;
            score_reg   <= entry_score;
            depth_reg   <= entry_depth;
            payload_reg <= entry_payload;
            count_reg   <= '0;
        end
        else if (count_hit)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg    <= '0;
            walk_reg   <= '0;
            cnt_en_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept && (cmd_t'(command) == CMD_CLEAR))
            begin
                age_reg <= '0;
            end
            else if (cfg_valid)
            begin
                age_reg <= cfg_data;
            end
            if (ctrl.accept)
            begin
                walk_reg <= '0;
            end
            else if (ctrl.walk_rd || ctrl.walk_clr)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
            cnt_en_reg <= ctrl.walk_rd;
        end
    end

    // output register: loads when empty or being drained
    assign load = ctrl.lookup_done || ctrl.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit         <= 1'b0;
            out_score   <= '0;
            out_depth   <= '0;
            out_payload <= '0;
            out_age     <= '0;
            stored      <= 1'b0;
            occupancy   <= '0;
            if (ctrl.lookup_done)
            begin
                if ((cmd_reg == CMD_READ) && key_match)
                begin
                    hit         <= 1'b1;
                    out_score   <= rd_score_adj;
                    out_depth   <= rd_data_reg.depth;
                    out_payload <= rd_data_reg.payload;
                    out_age     <= rd_data_reg.age;
                end
                if (cmd_reg == CMD_WRITE)
                begin
                    stored <= replace;
                end
            end
            else if (cmd_reg == CMD_OCCUPY)
            begin
                occupancy <= count_reg;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.walk_top     = &walk_reg;
    assign status.walk_occ_end = (walk_reg == INDEX_BITS'(OCC_SLOTS - 1));

endmodule

// File: hdl/transposition_table_top.sv
// Top level of the direct-mapped transposition table.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+----
//  cfg     | cfg_valid, cfg_ready, cfg_data (current age)     | in
//  in      | in_valid, in_ready, command, key, ply, entry_*   | in
//  out     | out_valid, out_ready, hit, out_*, stored, occ.   | out
//
// Read and write do one slot memory read, then compare and write back.
// Occupancy walks the first OCC_SLOTS slots, one slot memory read per cycle.
// Clear zeroes all 2^INDEX_BITS slots, one slot zeroed per cycle; it also zeroes the age.
// After reset a clearing pass over all 2^INDEX_BITS slots runs with in_ready low.
// A held result stalls only the following request; in_ready is low while one is in work.
`timescale 1ns / 1ps

module transposition_table_top
    import tt_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int MATE_SCORE = MATE_SCORE_DEF,
    parameter int MAX_PLY    = MAX_PLY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [AGE_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [KEY_W-1:0]            key,
    input  logic [PLY_W-1:0]            ply,
    input  logic signed [SCORE_W-1:0]   entry_score,
    input  logic signed [DEPTH_W-1:0]   entry_depth,
    input  logic [PAYLOAD_W-1:0]        entry_payload,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic signed [SCORE_W-1:0]   out_score,
    output logic signed [DEPTH_W-1:0]   out_depth,
    output logic [PAYLOAD_W-1:0]        out_payload,
    output logic [AGE_W-1:0]            out_age,
    output logic                        stored,
    output logic [OCC_W-1:0]            occupancy
);

    tt_ctrl_t   ctrl;
    tt_status_t status;

    assign cfg_ready = 1'b1;

    tt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    tt_datapath #(
        .INDEX_BITS (INDEX_BITS),
        .MATE_SCORE (MATE_SCORE),
        .MAX_PLY    (MAX_PLY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .command       (command),
        .key           (key),
        .ply           (ply),
        .entry_score   (entry_score),
        .entry_depth   (entry_depth),
        .entry_payload (entry_payload),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .hit           (hit),
        .out_score     (out_score),
        .out_depth     (out_depth),
        .out_payload   (out_payload),
        .out_age       (out_age),
        .stored        (stored),
        .occupancy     (occupancy),
        .ctrl          (ctrl),
        .status        (status)
    );

endmodule

// File: hdl/tt_checker.sv
// Port-level checker for the transposition table, bound to the top level.
`timescale 1ns / 1ps

module tt_checker
    import tt_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       hit,
    input logic signed [SCORE_W-1:0]  out_score,
    input logic                       stored,
    input logic [OCC_W-1:0]           occupancy
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(occupancy))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= OCC_W'(OCC_SLOTS))
        else $error("occupancy above walked slot count");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !stored && occupancy == '0)
        else $error("read hit mixed with other result fields");

endmodule

bind transposition_table_top tt_checker u_tt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .out_score (out_score),
    .stored    (stored),
    .occupancy (occupancy)
);

// File: tb/tb_transposition_table_top.sv
// Self-checking testbench for the transposition table: queued requests, predicted results.
`timescale 1ns / 1ps

module tb_transposition_table_top;
    import tt_pkg::*;

    localparam int SLOT_COUNT = 1 << INDEX_BITS_DEF;
    localparam int RUN_LIMIT  = 2000000;

    typedef struct packed {
        cmd_t                       command;
        logic [KEY_W-1:0]           key;
        logic [PLY_W-1:0]           ply;
        logic signed [SCORE_W-1:0]  score;
        logic signed [DEPTH_W-1:0]  depth;
        logic [PAYLOAD_W-1:0]       payload;
    } tt_req_t;

    typedef struct packed {
        logic                       hit;
        logic signed [SCORE_W-1:0]  score;
        logic signed [DEPTH_W-1:0]  depth;
        logic [PAYLOAD_W-1:0]       payload;
        logic [AGE_W-1:0]           age;
        logic                       stored;
        logic [OCC_W-1:0]           occupancy;
    } tt_resp_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [AGE_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command = '0;
    logic [KEY_W-1:0]           key = '0;
    logic [PLY_W-1:0]           ply = '0;
    logic signed [SCORE_W-1:0]  entry_score = '0;
    logic signed [DEPTH_W-1:0]  entry_depth = '0;
    logic [PAYLOAD_W-1:0]       entry_payload = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       hit;
    logic signed [SCORE_W-1:0]  out_score;
    logic signed [DEPTH_W-1:0]  out_depth;
    logic [PAYLOAD_W-1:0]       out_payload;
    logic [AGE_W-1:0]           out_age;
    logic                       stored;
    logic [OCC_W-1:0]           occupancy;

    slot_t            table_mem [0:SLOT_COUNT-1];
    logic [AGE_W-1:0] age_reg;
    tt_req_t          pending_reqs [$];
    tt_resp_t         due_results [$];
    logic [KEY_W-1:0] recent_keys [$];
    tt_req_t          cur_req;
    tt_resp_t         got_resp;
    tt_resp_t         want_resp;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    logic             hold_go = 1'b0;
    logic             hold_seen;
    int               hold_left;
    int               fault_count = 0;
    int               result_count = 0;
    int               cycle_count = 0;

    transposition_table_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .key           (key),
        .ply           (ply),
        .entry_score   (entry_score),
        .entry_depth   (entry_depth),
        .entry_payload (entry_payload),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .out_score     (out_score),
        .out_depth     (out_depth),
        .out_payload   (out_payload),
        .out_age       (out_age),
        .stored        (stored),
        .occupancy     (occupancy)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void wipe_table();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            table_mem[i] = '0;
        end
    endfunction

    function automatic int mate_shift(int s, int p, int dir);
        int lim;
        lim = MATE_SCORE_DEF - MAX_PLY_DEF;
        if (s >= lim)
            s = s + dir * p;
        else if (s <= -lim)
            s = s - dir * p;
        if (s > 32767)
            s = 32767;
        if (s < -32767)
            s = -32767;
        return s;
    endfunction

    function automatic tt_resp_t table_access(tt_req_t r);
        tt_resp_t res;
        int       idx;
        int       count;
        res = '0;
        idx = int'(r.key[INDEX_BITS_DEF-1:0]);
        case (r.command)
            CMD_READ:
            begin
                if (table_mem[idx].key == r.key)
                begin
                    res.hit     = 1'b1;
                    res.score   = SCORE_W'(mate_shift($signed(table_mem[idx].score),
                                                      int'(r.ply), -1));
                    res.depth   = table_mem[idx].depth;
                    res.payload = table_mem[idx].payload;
                    res.age     = table_mem[idx].age;
                end
            end
            CMD_WRITE:
            begin
                if (table_mem[idx].age != age_reg
                    || $signed(r.depth) >= $signed(table_mem[idx].depth))
                begin
                    table_mem[idx].key     = r.key;
                    table_mem[idx].score   = SCORE_W'(mate_shift($signed(r.score),
                                                                 int'(r.ply), 1));
                    table_mem[idx].depth   = r.depth;
                    table_mem[idx].payload = r.payload;
                    table_mem[idx].age     = age_reg;
                    res.stored = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                wipe_table();
                age_reg = '0;
            end
            default:
            begin
                count = 0;
                for (int i = 0; i < OCC_SLOTS; i++)
                begin
                    if (table_mem[i].key != '0 && table_mem[i].age == age_reg)
                        count++;
                end
                res.occupancy = OCC_W'(count);
            end
        endcase
        return res;
    endfunction

    function automatic tt_req_t mk_req(cmd_t c, logic [KEY_W-1:0] k, logic [PLY_W-1:0] p,
                                       logic signed [SCORE_W-1:0] s,
                                       logic signed [DEPTH_W-1:0] d,
                                       logic [PAYLOAD_W-1:0] pl);
        tt_req_t r;
        r.command = c;
        r.key     = k;
        r.ply     = p;
        r.score   = s;
        r.depth   = d;
        r.payload = pl;
        return r;
    endfunction

    function automatic tt_req_t gen_request();
        tt_req_t r;
        int      pick;
        int      sub;
        pick = $urandom_range(99);
        sub  = $urandom_range(9);
        if (pick < 4)
            r.command = CMD_OCCUPY;
        else if (pick < 48)
            r.command = CMD_READ;
        else
            r.command = CMD_WRITE;
        r.key     = {32'($urandom), 32'($urandom)};
        r.ply     = PLY_W'($urandom);
        r.depth   = DEPTH_W'($urandom);
        r.payload = PAYLOAD_W'($urandom);
        case ($urandom_range(3))
            0: r.score = SCORE_W'($urandom);
            1: r.score = SCORE_W'($urandom_range(31800, 32767));
            2: r.score = SCORE_W'(0 - int'($urandom_range(31800, 32768)));
            default: r.score = SCORE_W'(int'($urandom_range(400)) - 200);
        endcase
        if (r.command == CMD_WRITE)
        begin
            if (sub < 4 && recent_keys.size() != 0)
                r.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            else if (sub < 8)
                r.key[15:0] = 16'($urandom_range(1999));
            recent_keys.push_back(r.key);
            if (recent_keys.size() > 48)
                void'(recent_keys.pop_front());
        end
        else if (r.command == CMD_READ && recent_keys.size() != 0)
        begin
            if (sub < 6)
                r.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            else if (sub < 8)
                r.key = recent_keys[$urandom_range(recent_keys.size() - 1)]
                        ^ {16'($urandom) | 16'd1, 48'd0};
        end
        return r;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0);
    endtask

    task automatic set_age(input logic [AGE_W-1:0] age);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= age;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        age_reg = age;
    endtask

    task automatic push_random(input int count, input int clear_at);
        tt_req_t r;
        for (int n = 0; n < count; n++)
        begin
            r = gen_request();
            if (n == clear_at)
                r.command = CMD_CLEAR;
            pending_reqs.push_back(r);
        end
    endtask

    task automatic run_phase(input logic [AGE_W-1:0] age, input int idle, input int stall,
                             input int count, input int clear_at);
        wait_drained();
        send_idle_pct = idle;
        stall_pct     = stall;
        set_age(age);
        push_random(count, clear_at);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                due_results.push_back(table_access(cur_req));
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid      <= 1'b1;
                    command       <= cur_req.command;
                    key           <= cur_req.key;
                    ply           <= cur_req.ply;
                    entry_score   <= cur_req.score;
                    entry_depth   <= cur_req.depth;
                    entry_payload <= cur_req.payload;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= 400;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                got_resp.hit       = hit;
                got_resp.score     = out_score;
                got_resp.depth     = out_depth;
                got_resp.payload   = out_payload;
                got_resp.age       = out_age;
                got_resp.stored    = stored;
                got_resp.occupancy = occupancy;
                if (due_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result %0d arrived with no request outstanding",
                                 result_count);
                end
                else
                begin
                    want_resp = due_results.pop_front();
                    if (want_resp.hit !== got_resp.hit
                        || want_resp.score !== got_resp.score
                        || want_resp.depth !== got_resp.depth
                        || want_resp.payload !== got_resp.payload
                        || want_resp.age !== got_resp.age
                        || want_resp.stored !== got_resp.stored
                        || want_resp.occupancy !== got_resp.occupancy)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $write("result %0d expected: hit=%0d score=%0d depth=%0d",
                                   result_count, want_resp.hit, want_resp.score,
                                   want_resp.depth);
                            $display(" payload=%h age=%0d stored=%0d occ=%0d",
                                     want_resp.payload, want_resp.age,
                                     want_resp.stored, want_resp.occupancy);
                            $write("result %0d actual:   hit=%0d score=%0d depth=%0d",
                                   result_count, got_resp.hit, got_resp.score,
                                   got_resp.depth);
                            $display(" payload=%h age=%0d stored=%0d occ=%0d",
                                     got_resp.payload, got_resp.age,
                                     got_resp.stored, got_resp.occupancy);
                        end
                    end
                end
            end
            if (hold_go != hold_seen || hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        tt_req_t r;
        wipe_table();
        age_reg = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        pending_reqs.push_back(mk_req(CMD_READ, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0123_4567_89ab_0005, 7'd0, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_OCCUPY, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'h0123_4567_89ab_0005, 7'd0, 16'sd100,
                                      -8'sd1, 16'h1234));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'h0123_4567_89ab_0005, 7'd127,
                                      16'sd32767, 8'sd0, 16'hffff));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0123_4567_89ab_0005, 7'd127, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'hfedc_ba98_7654_0005, 7'd0, 16'sd5,
                                      8'sh80, 16'h5555));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'hfedc_ba98_7654_0005, 7'd5, 16'sh8000,
                                      8'sd127, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0123_4567_89ab_0005, 7'd0, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_READ, 64'hfedc_ba98_7654_0005, 7'd0, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'h0000_0000_0000_0009, 7'd10,
                                      16'sd31872, 8'sd3, 16'haaaa));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0000_0000_0000_0009, 7'd3, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'h0000_0000_0000_000a, 7'd127,
                                      -16'sd31872, 8'sd3, 16'h0f0f));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0000_0000_0000_000a, 7'd127, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'h0000_0000_0000_000b, 7'd100,
                                      16'sd31871, 8'sd1, 16'hf0f0));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0000_0000_0000_000b, 7'd100, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'hffff_ffff_ffff_ffff, 7'd7,
                                      -16'sd31871, 8'sd5, 16'h8001));
        pending_reqs.push_back(mk_req(CMD_READ, 64'hffff_ffff_ffff_ffff, 7'd7, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_OCCUPY, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));
        wait_drained();
        set_age(6'd63);
        pending_reqs.push_back(mk_req(CMD_WRITE, 64'h0123_4567_89ab_0005, 7'd1, 16'sd77,
                                      8'sh80, 16'h4321));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0123_4567_89ab_0005, 7'd1, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_OCCUPY, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_CLEAR, 64'hffff_ffff_ffff_ffff, 7'd127,
                                      16'sh7fff, 8'sh7f, 16'hffff));
        pending_reqs.push_back(mk_req(CMD_READ, 64'h0123_4567_89ab_0005, 7'd0, 16'sd0,
                                      8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_READ, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));
        pending_reqs.push_back(mk_req(CMD_OCCUPY, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));

        // fill the counted window under a fresh age, then flood with a held output
        run_phase(6'd63, 0, 0, 0, -1);
        for (int slot = 0; slot < OCC_SLOTS; slot++)
        begin
            r = gen_request();
            r.command = CMD_WRITE;
            r.key = {32'($urandom), 16'($urandom), 16'(slot)};
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(mk_req(CMD_OCCUPY, 64'd0, 7'd0, 16'sd0, 8'sd0, 16'h0000));
        hold_go = ~hold_go;
        push_random(200, -1);

        run_phase(AGE_W'($urandom_range(1, 62)), 81, 0, 150, 120);
        run_phase(6'd0, 0, 81, 150, -1);
        run_phase(AGE_W'($urandom_range(1, 62)), 30, 30, 150, 100);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fault_count == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: transposition_table_top.f
hdl/tt_pkg.sv
hdl/tt_ctrl.sv
hdl/tt_datapath.sv
hdl/transposition_table_top.sv
hdl/tt_checker.sv
tb/tb_transposition_table_top.sv
